/* design/f2i_pkg.sv */
// ----------------------------------------------------------------------------
// f2i_pkg
// Types, command codes and helpers for the float to integer converter.
// ----------------------------------------------------------------------------
package f2i_pkg;

  localparam logic [3:0] CMD_S8   = 4'd0;
  localparam logic [3:0] CMD_U8   = 4'd1;
  localparam logic [3:0] CMD_S16  = 4'd2;
  localparam logic [3:0] CMD_U16  = 4'd3;
  localparam logic [3:0] CMD_S32  = 4'd4;
  localparam logic [3:0] CMD_U32  = 4'd5;
  localparam logic [3:0] CMD_S64  = 4'd6;
  localparam logic [3:0] CMD_U64  = 4'd7;
  localparam logic [3:0] CMD_BITS = 4'd8;

  localparam logic [31:0] CANON_NAN = 32'h7fc00000;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] value_bits;
  } f2i_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        is_nan;
    logic        is_infinite;
    logic        saturated;
  } f2i_out_t;

  // stage 1 to stage 2: decoded operand
  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] value_bits;
    logic        neg;
    logic        nan;
    logic        inf;
    logic        big;
    logic        ge_one;
    logic [5:0]  e;
    logic [23:0] mant;
  } f2i_dec_t;

  // stage 2 to stage 3: magnitude
  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] value_bits;
    logic        neg;
    logic        nan;
    logic        inf;
    logic        big;
    logic [63:0] mag;
  } f2i_mag_t;

endpackage

/* design/f2i_decode.sv */
// ----------------------------------------------------------------------------
// f2i_decode
// Splits the operand into sign, exponent and significand fields.
// ----------------------------------------------------------------------------
module f2i_decode (
  input  f2i_pkg::f2i_in_t  in_item,
  output f2i_pkg::f2i_dec_t dec
);
  logic [7:0] ex;
  logic [7:0] eu;
  always_comb begin
    ex = in_item.value_bits[30:23];
    eu = ex - 8'd127;
    dec.command    = in_item.command;
    dec.value_bits = in_item.value_bits;
    dec.neg        = in_item.value_bits[31];
    dec.nan        = (ex == 8'hff) && (in_item.value_bits[22:0] != 23'd0);
    dec.inf        = (ex == 8'hff) && (in_item.value_bits[22:0] == 23'd0);
    dec.big        = (ex == 8'hff) || (ex >= 8'd191);
    dec.ge_one     = (ex >= 8'd127);
    dec.e          = eu[5:0];
    dec.mant       = {1'b1, in_item.value_bits[22:0]};
  end
endmodule

/* design/f2i_shift.sv */
// ----------------------------------------------------------------------------
// f2i_shift
// Aligns the significand to an integer magnitude, truncating toward zero.
// ----------------------------------------------------------------------------
module f2i_shift (
  input  f2i_pkg::f2i_dec_t dec,
  output f2i_pkg::f2i_mag_t mo
);
  logic [86:0] wide;
  always_comb begin
    // value = mant * 2^(e-23); shift left by e then drop 23 fraction bits
    wide = {63'd0, dec.mant} << dec.e;
    mo.command    = dec.command;
    mo.value_bits = dec.value_bits;
    mo.neg        = dec.neg;
    mo.nan        = dec.nan;
    mo.inf        = dec.inf;
    mo.big        = dec.big;
    mo.mag        = (dec.ge_one && !dec.big) ? wide[86:23] : 64'd0;
  end
endmodule

/* design/f2i_clamp.sv */
// ----------------------------------------------------------------------------
// f2i_clamp
// Range check and saturation against the chosen target type.
// ----------------------------------------------------------------------------
module f2i_clamp (
  input  f2i_pkg::f2i_mag_t mi,
  output f2i_pkg::f2i_out_t res
);
  logic [6:0]  nbits;
  logic [63:0] half;
  logic [63:0] umax;
  logic        signed_t;
  always_comb begin
    nbits    = 7'd8 << mi.command[2:1];
    half     = 64'd1 << (nbits - 7'd1);
    umax     = (mi.command[2:1] == 2'd3) ? '1 : ((64'd1 << nbits) - 64'd1);
    signed_t = !mi.command[0];
    res.result_bits = '0;
    res.saturated   = 1'b0;
    res.is_nan      = mi.nan;
    res.is_infinite = mi.inf;
    if (mi.command == f2i_pkg::CMD_BITS) begin
      res.result_bits = mi.nan ? {32'd0, f2i_pkg::CANON_NAN} : {32'd0, mi.value_bits};
    end else if (!mi.command[3] && !mi.nan) begin
      if (signed_t) begin
        if (!mi.neg) begin
          if (mi.big || mi.mag > half - 64'd1) begin
            res.result_bits = half - 64'd1;
            res.saturated   = 1'b1;
          end else begin
            res.result_bits = mi.mag;
          end
        end else if (mi.big || mi.mag > half) begin
          res.result_bits = 64'd0 - half;
          res.saturated   = 1'b1;
        end else begin
          res.result_bits = 64'd0 - mi.mag;
        end
      end else if (mi.neg) begin
        res.saturated = mi.big || (mi.mag != 64'd0);
      end else if (mi.big || mi.mag > umax) begin
        res.result_bits = umax;
        res.saturated   = 1'b1;
      end else begin
        res.result_bits = mi.mag;
      end
    end
  end
endmodule

/* design/float_to_int_saturating_convert.sv */
// ----------------------------------------------------------------------------
// float_to_int_saturating_convert
// Single-precision to integer conversion with truncation and saturation.
// ----------------------------------------------------------------------------
// stages: decode, align and clamp, each followed by its own register
// throughput: one item per cycle while out_ready holds; each stage advances when the next is free
// reset: rst_n synchronous active low clears all stage valid bits
module float_to_int_saturating_convert (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  f2i_pkg::f2i_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output f2i_pkg::f2i_out_t out_data
);
  f2i_pkg::f2i_dec_t dec, s1_r;
  f2i_pkg::f2i_mag_t mag, s2_r;
  f2i_pkg::f2i_out_t res, s3_r;
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  f2i_decode u_dec (.in_item(in_data), .dec(dec));
  f2i_shift  u_shf (.dec(s1_r), .mo(mag));
  f2i_clamp  u_clp (.mi(s2_r), .res(res));

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= dec;
    if (en2) s2_r <= mag;
    if (en3) s3_r <= res;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;
endmodule

/* tb/float_to_int_saturating_convert_tb.sv */
// ----------------------------------------------------------------------------
// float_to_int_saturating_convert_tb
// Drives single-precision operands with every command through the converter,
// predicts each result from the operand's bit fields and checks it in order.
// ----------------------------------------------------------------------------
module float_to_int_saturating_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  f2i_pkg::f2i_in_t   in_data;
  logic               out_valid;
  logic               out_ready;
  f2i_pkg::f2i_out_t  out_data;

  f2i_pkg::f2i_in_t   pending_items[$];
  f2i_pkg::f2i_out_t  expected_results[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       mismatches;
  int       checked;
  int       idle_cycles;
  bit       timed_out;
  int       cmd_seen[16];

  float_to_int_saturating_convert i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // truncate toward zero and clamp to the target selected by the command, or pass the raw bits for CMD_BITS
  function automatic f2i_pkg::f2i_out_t convert_operand(f2i_pkg::f2i_in_t item);
    f2i_pkg::f2i_out_t r;
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] frac;
    logic        big;
    logic [63:0] mag;
    logic [63:0] m;
    logic [63:0] half;
    logic [63:0] lim;
    int          e;
    int          nbits;
    neg  = item.value_bits[31];
    ex   = item.value_bits[30:23];
    frac = item.value_bits[22:0];
    r = '0;
    r.is_nan      = (ex == 8'hff) && (frac != 0);
    r.is_infinite = (ex == 8'hff) && (frac == 0);
    big = (ex == 8'hff) || (ex >= 8'd191);
    mag = '0;
    if (!big && ex >= 8'd127) begin
      e = ex - 127;
      m = {40'd0, 1'b1, frac};
      mag = (e >= 23) ? (m << (e - 23)) : (m >> (23 - e));
    end
    if (item.command == f2i_pkg::CMD_BITS) begin
      r.result_bits = r.is_nan ? {32'd0, f2i_pkg::CANON_NAN} : {32'd0, item.value_bits};
    end else if (item.command < f2i_pkg::CMD_BITS && !r.is_nan) begin
      nbits = 8 << (item.command >> 1);
      if (!item.command[0]) begin
        half = 64'd1 << (nbits - 1);
        if (!neg) begin
          if (big || mag > half - 1) begin
            r.result_bits = half - 1;
            r.saturated = 1'b1;
          end else begin
            r.result_bits = mag;
          end
        end else begin
          if (big || mag > half) begin
            r.result_bits = -half;
            r.saturated = 1'b1;
          end else begin
            r.result_bits = -mag;
          end
        end
      end else begin
        lim = (nbits == 64) ? '1 : ((64'd1 << nbits) - 1);
        if (neg) begin
          r.saturated = big || (mag != 0);
        end else if (big || mag > lim) begin
          r.result_bits = lim;
          r.saturated = 1'b1;
        end else begin
          r.result_bits = mag;
        end
      end
    end
    return r;
  endfunction

  function automatic f2i_pkg::f2i_in_t make_item(logic [3:0] cmd, logic [31:0] bits);
    f2i_pkg::f2i_in_t it;
    it.command    = cmd;
    it.value_bits = bits;
    return it;
  endfunction

  // operands clustered around the interesting exponents of each target
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    int          pick;
    v = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: v[30:23] = 8'd127 + 8'($urandom_range(0, 64));
      3: v[30:23] = 8'd120 + 8'($urandom_range(0, 8));
      4: begin
        v[30:23] = 8'd127 + 8'd7 + 8'(8 * $urandom_range(0, 7));
        v[22:0] = ($urandom_range(0, 1) == 1) ? 23'd0 : v[22:0];
      end
      5: v[30:23] = 8'hff;
      6: v[30:0] = 31'd0;
      default: ;
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_results.push_back(convert_operand(in_data));
        cmd_seen[in_data.command]++;
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    f2i_pkg::f2i_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result item: %h", out_data);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected res=%h nan=%b inf=%b sat=%b",
                       want.result_bits, want.is_nan, want.is_infinite, want.saturated);
              $display("          actual   res=%h nan=%b inf=%b sat=%b",
                       out_data.result_bits, out_data.is_nan, out_data.is_infinite,
                       out_data.saturated);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out <= 1'b1;
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("float_to_int_saturating_convert verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed_ops[$];
    int          phase;
    int          c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    checked = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 61;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero, signs, fractions, limits, exact power-of-two bounds, inf, nan
    directed_ops = '{32'h00000000, 32'h80000000, 32'hbf000000, 32'h42ffcccd,
                     32'h43000000, 32'hc3000000, 32'h43800000, 32'h47000000,
                     32'hc7000000, 32'h4f000000, 32'hcf000000, 32'h4f800000,
                     32'h5f000000, 32'hdf000000, 32'h5f800000, 32'h7f7fffff,
                     32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffffffff,
                     32'h7f800001, 32'h3f800000, 32'hc3010000, 32'h00000001};
    foreach (directed_ops[i]) begin
      pending_items.push_back(make_item(4'(i % 9), directed_ops[i]));
    end
    for (c = 0; c < 16; c++) begin
      pending_items.push_back(make_item(4'(c), 32'hcf000000));
      pending_items.push_back(make_item(4'(c), 32'h7fa00000));
    end
    // every directed operand at every target
    foreach (directed_ops[i]) begin
      for (c = 0; c <= 8; c++) pending_items.push_back(make_item(4'(c), directed_ops[i]));
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 24 : 0;
      repeat (193) begin
        c = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        pending_items.push_back(make_item(4'(c), random_operand()));
      end
      wait (pending_items.size() == 0 && !in_valid);
    end
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d result items across 16 commands (%0d s64, %0d u64, %0d bits)",
             checked, cmd_seen[f2i_pkg::CMD_S64], cmd_seen[f2i_pkg::CMD_U64],
             cmd_seen[f2i_pkg::CMD_BITS]);
    $display("directed limits, infinities, nans and three handshake idle mixes");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("float_to_int_saturating_convert verification clean");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_results.size());
      $display("float_to_int_saturating_convert verification failed");
    end
    $finish;
  end

endmodule
